FILE: hw/rtl/detsg_pkg.sv
// detsg_pkg: shared types and constants of the dual echo timer servo gate
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package detsg_pkg;

    localparam int WidthW   = 16;
    localparam int FrameW   = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_WINDOW_A_LOW  = 3'd0,
        CFG_WINDOW_A_HIGH = 3'd1,
        CFG_WINDOW_B_LOW  = 3'd2,
        CFG_WINDOW_B_HIGH = 3'd3,
        CFG_FRAME_LENGTH  = 3'd4,
        CFG_SHORT_PULSE   = 3'd5,
        CFG_LONG_PULSE    = 3'd6
    } cfg_idx_t;

    localparam logic [WidthW-1:0] WindowALowRst  = 16'd90;
    localparam logic [WidthW-1:0] WindowAHighRst = 16'd120;
    localparam logic [WidthW-1:0] WindowBLowRst  = 16'd120;
    localparam logic [WidthW-1:0] WindowBHighRst = 16'd150;
    localparam logic [FrameW-1:0] FrameLengthRst = 8'd200;
    localparam logic [FrameW-1:0] ShortPulseRst  = 8'd15;
    localparam logic [FrameW-1:0] LongPulseRst   = 8'd17;

    localparam logic [2:0] OutAllHigh = 3'b111;

    typedef struct packed {
        logic [WidthW-1:0] window_a_low;
        logic [WidthW-1:0] window_a_high;
        logic [WidthW-1:0] window_b_low;
        logic [WidthW-1:0] window_b_high;
        logic [FrameW-1:0] frame_length;
        logic [FrameW-1:0] short_pulse_count;
        logic [FrameW-1:0] long_pulse_count;
    } cfg_t;

    typedef struct packed {
        logic [WidthW-1:0] width_a;
        logic [WidthW-1:0] width_b;
    } widths_t;

endpackage

FILE: hw/rtl/detsg_in_if.sv
// detsg_in_if: input channel carrying echo levels and tick strobes
// uses no package
`timescale 1ns / 1ps

interface detsg_in_if;
    logic valid;
    logic ready;
    logic echo_a;
    logic echo_b;
    logic count_tick;
    logic frame_tick;

    modport source (output valid, output echo_a, output echo_b, output count_tick,
                    output frame_tick, input ready);
    modport sink   (input valid, input echo_a, input echo_b, input count_tick,
                    input frame_tick, output ready);
endinterface

FILE: hw/rtl/detsg_out_if.sv
// detsg_out_if: result channel carrying servo outputs and captured widths
// uses no package
`timescale 1ns / 1ps

interface detsg_out_if;
    logic        valid;
    logic        ready;
    logic        servo_a;
    logic        servo_b;
    logic        aux_out;
    logic [15:0] width_a;
    logic [15:0] width_b;

    modport source (output valid, output servo_a, output servo_b, output aux_out,
                    output width_a, output width_b, input ready);
    modport sink   (input valid, input servo_a, input servo_b, input aux_out,
                    input width_a, input width_b, output ready);
endinterface

FILE: hw/rtl/detsg_cfg.sv
// detsg_cfg: configuration register file with plain write port
// depends on detsg_pkg
`timescale 1ns / 1ps

module detsg_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [detsg_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [detsg_pkg::CfgDataW-1:0] cfg_data,
    output detsg_pkg::cfg_t               cfg
);
    import detsg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_A_LOW:  cfg_next.window_a_low      = cfg_data;
                CFG_WINDOW_A_HIGH: cfg_next.window_a_high     = cfg_data;
                CFG_WINDOW_B_LOW:  cfg_next.window_b_low      = cfg_data;
                CFG_WINDOW_B_HIGH: cfg_next.window_b_high     = cfg_data;
                CFG_FRAME_LENGTH:  cfg_next.frame_length      = cfg_data[FrameW-1:0];
                CFG_SHORT_PULSE:   cfg_next.short_pulse_count = cfg_data[FrameW-1:0];
                CFG_LONG_PULSE:    cfg_next.long_pulse_count  = cfg_data[FrameW-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_a_low      <= WindowALowRst;
            cfg_reg.window_a_high     <= WindowAHighRst;
            cfg_reg.window_b_low      <= WindowBLowRst;
            cfg_reg.window_b_high     <= WindowBHighRst;
            cfg_reg.frame_length      <= FrameLengthRst;
            cfg_reg.short_pulse_count <= ShortPulseRst;
            cfg_reg.long_pulse_count  <= LongPulseRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/detsg_echo.sv
// detsg_echo: echo edge detection, shared width counter and width capture
// depends on detsg_pkg
`timescale 1ns / 1ps

module detsg_echo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               echo_a,
    input  logic               echo_b,
    input  logic               count_tick,
    output detsg_pkg::widths_t widths_next,
    output detsg_pkg::widths_t widths
);
    import detsg_pkg::*;

    logic              prev_a_reg;
    logic              prev_b_reg;
    logic              count_en_reg;
    logic [WidthW-1:0] count_reg;
    widths_t           widths_reg;

    logic              count_en_mid;
    logic              count_en_next;
    logic [WidthW-1:0] count_tick_val;
    logic [WidthW-1:0] count_mid;
    logic [WidthW-1:0] count_next;

    always_comb
    begin
        count_tick_val = (count_tick && count_en_reg) ? count_reg + WidthW'(1) : count_reg;

        // echo a first
        count_mid           = count_tick_val;
        count_en_mid        = count_en_reg;
        widths_next.width_a = widths_reg.width_a;
        if (echo_a != prev_a_reg)
        begin
            if (echo_a)
            begin
                count_mid           = '0;
                widths_next.width_a = '0;
                count_en_mid        = 1'b1;
            end
            else
            begin
                widths_next.width_a = count_tick_val;
                count_en_mid        = 1'b0;
            end
        end

        // then echo b
        count_next          = count_mid;
        count_en_next       = count_en_mid;
        widths_next.width_b = widths_reg.width_b;
        if (echo_b != prev_b_reg)
        begin
            if (echo_b)
            begin
                count_next          = '0;
                widths_next.width_b = '0;
                count_en_next       = 1'b1;
            end
            else
            begin
                widths_next.width_b = count_mid;
                count_en_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg   <= 1'b0;
            prev_b_reg   <= 1'b0;
            count_en_reg <= 1'b0;
            count_reg    <= '0;
            widths_reg   <= '0;
        end
        else if (step)
        begin
            prev_a_reg   <= echo_a;
            prev_b_reg   <= echo_b;
            count_en_reg <= count_en_next;
            count_reg    <= count_next;
            widths_reg   <= widths_next;
        end
    end

    assign widths = widths_reg;

endmodule

FILE: hw/rtl/detsg_servo.sv
// detsg_servo: frame counter and window-gated servo pulse outputs
// depends on detsg_pkg
`timescale 1ns / 1ps

module detsg_servo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               frame_tick,
    input  detsg_pkg::cfg_t    cfg,
    input  detsg_pkg::widths_t widths_next,
    output logic [2:0]         out_bits
);
    import detsg_pkg::*;

    logic [FrameW-1:0] frame_reg;
    logic [FrameW-1:0] frame_next;
    logic [FrameW-1:0] frame_inc;
    logic [2:0]        out_bits_reg;
    logic [2:0]        out_bits_next;
    logic              in_a;
    logic              in_b;

    always_comb
    begin
        in_a = (widths_next.width_a > cfg.window_a_low) &&
               (widths_next.width_a < cfg.window_a_high);
        in_b = (widths_next.width_b > cfg.window_b_low) &&
               (widths_next.width_b < cfg.window_b_high);
        frame_inc     = frame_reg + FrameW'(1);
        frame_next    = frame_reg;
        out_bits_next = out_bits_reg;
        if (frame_tick)
        begin
            frame_next = frame_inc;
            // frame start
            if (frame_inc > cfg.frame_length)
            begin
                frame_next    = '0;
                out_bits_next = OutAllHigh;
            end
            if (frame_next == cfg.short_pulse_count)
            begin
                if (in_a)
                    out_bits_next[0] = 1'b0;
                if (in_b)
                    out_bits_next[1] = 1'b0;
            end
            if (frame_next == cfg.long_pulse_count)
            begin
                if (!in_a)
                    out_bits_next[0] = 1'b0;
                if (!in_b)
                    out_bits_next[1] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg    <= '0;
            out_bits_reg <= '0;
        end
        else if (step)
        begin
            frame_reg    <= frame_next;
            out_bits_reg <= out_bits_next;
        end
    end

    assign out_bits = out_bits_reg;

endmodule

FILE: hw/rtl/dual_echo_timer_servo_gate_top.sv
// dual_echo_timer_servo_gate_top: result valid is registered and rises in the cycle after an input transfer
// throughput one item per cycle unless out_ch.ready stalls; the state registers double as the result register
// a new input is taken whenever the result register is empty or drained the same cycle
// reset clears all state and outputs and loads the default configuration
// depends on detsg_pkg, detsg_in_if, detsg_out_if, detsg_cfg, detsg_echo, detsg_servo
`timescale 1ns / 1ps

module dual_echo_timer_servo_gate_top (
    input  logic                           clk,
    input  logic                           rst_n,
    detsg_in_if.sink                       in_ch,
    detsg_out_if.source                    out_ch,
    input  logic                           cfg_we,
    input  logic [detsg_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [detsg_pkg::CfgDataW-1:0] cfg_data
);
    import detsg_pkg::*;

    cfg_t       cfg;
    widths_t    widths_next;
    widths_t    widths;
    logic [2:0] out_bits;
    logic       out_valid_reg;
    logic       step;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign step        = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ch.ready)
            out_valid_reg <= in_ch.valid;
    end

    detsg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    detsg_echo u_echo (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .echo_a      (in_ch.echo_a),
        .echo_b      (in_ch.echo_b),
        .count_tick  (in_ch.count_tick),
        .widths_next (widths_next),
        .widths      (widths)
    );

    detsg_servo u_servo (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .frame_tick  (in_ch.frame_tick),
        .cfg         (cfg),
        .widths_next (widths_next),
        .out_bits    (out_bits)
    );

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.servo_a = out_bits[0];
    assign out_ch.servo_b = out_bits[1];
    assign out_ch.aux_out = out_bits[2];
    assign out_ch.width_a = widths.width_a;
    assign out_ch.width_b = widths.width_b;

endmodule
